[hw/rtl/ubx_nav_pvt_frame_parser_assert.svh]
// assertion macros shared by the frame parser rtl
`ifndef UBX_NAV_PVT_FRAME_PARSER_ASSERT_SVH
`define UBX_NAV_PVT_FRAME_PARSER_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication, sampled on clk, quiet during reset
`define UBX_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, sampled on clk, quiet during reset
`define UBX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define UBX_ASSERT_IMPLY(label, ante, cons, msg)
`define UBX_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

[hw/rtl/ubxpvt_pkg.sv]
// shared constants and result type of the navigation frame parser
package ubxpvt_pkg;

    // framing bytes
    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;

    // carrier solution flags
    localparam logic [7:0] FLAG_FIXED = 8'h83;
    localparam logic [7:0] FLAG_FLOAT = 8'h43;

    // mapped fix codes
    localparam logic [7:0] FIX_NONE_MAPPED = 8'd1;
    localparam logic [7:0] FIX_RTK_FIXED   = 8'd4;
    localparam logic [7:0] FIX_RTK_FLOAT   = 8'd5;

    // configuration reset values and register indexes
    localparam logic [7:0] MESSAGE_ID_RESET  = 8'h07;
    localparam logic [6:0] MAX_LEN_RESET     = 7'd120;
    localparam logic       CFG_MESSAGE_ID    = 1'b0;
    localparam logic       CFG_MAX_LEN       = 1'b1;

    // only payload bytes below this index feed any result field
    localparam int FIELD_BYTES = 78;

    localparam logic [19:0] SEC_PER_HOUR = 20'd3600;
    localparam logic [19:0] SEC_PER_MIN  = 20'd60;

    typedef struct packed {
        logic [19:0]        time_of_day_s;
        logic [7:0]         fix_type;
        logic [7:0]         sat_count;
        logic signed [31:0] longitude_e7;
        logic signed [31:0] latitude_e7;
        logic signed [31:0] height_msl_mm;
        logic signed [31:0] vel_north_mm_s;
        logic signed [31:0] vel_east_mm_s;
        logic signed [31:0] vel_down_mm_s;
        logic [31:0]        ground_speed_mm_s;
        logic [31:0]        heading_e5;
        logic [15:0]        hdop_centi;
    } nav_result_t;

endpackage

[hw/rtl/ubxpvt_decode.sv]
// field decoder: turns stored payload bytes into one navigation result
module ubxpvt_decode (
    input  logic [7:0]              pbytes [ubxpvt_pkg::FIELD_BYTES],
    output ubxpvt_pkg::nav_result_t result
);
    import ubxpvt_pkg::*;

    logic [7:0] fix_base;

    // little-endian word at a fixed offset
    function automatic logic [31:0] word_at(input logic [7:0] b0, input logic [7:0] b1,
                                            input logic [7:0] b2, input logic [7:0] b3);
        word_at = {b3, b2, b1, b0};
    endfunction

    // all result fields from the stored bytes
    always_comb
    begin
        // fix type: zero becomes one, carrier flags override
        fix_base = (pbytes[20] == 8'd0) ? FIX_NONE_MAPPED : pbytes[20];
        case (pbytes[21])
            FLAG_FIXED: result.fix_type = FIX_RTK_FIXED;
            FLAG_FLOAT: result.fix_type = FIX_RTK_FLOAT;
            default:    result.fix_type = fix_base;
        endcase

        // time of day from hour, minute, second
        result.time_of_day_s = 20'(pbytes[8]) * SEC_PER_HOUR
                             + 20'(pbytes[9]) * SEC_PER_MIN
                             + 20'(pbytes[10]);

        result.sat_count         = pbytes[23];
        result.longitude_e7      = word_at(pbytes[24], pbytes[25], pbytes[26], pbytes[27]);
        result.latitude_e7       = word_at(pbytes[28], pbytes[29], pbytes[30], pbytes[31]);
        result.height_msl_mm     = word_at(pbytes[36], pbytes[37], pbytes[38], pbytes[39]);
        result.vel_north_mm_s    = word_at(pbytes[48], pbytes[49], pbytes[50], pbytes[51]);
        result.vel_east_mm_s     = word_at(pbytes[52], pbytes[53], pbytes[54], pbytes[55]);
        result.vel_down_mm_s     = word_at(pbytes[56], pbytes[57], pbytes[58], pbytes[59]);
        result.ground_speed_mm_s = word_at(pbytes[60], pbytes[61], pbytes[62], pbytes[63]);
        result.heading_e5        = word_at(pbytes[64], pbytes[65], pbytes[66], pbytes[67]);
        result.hdop_centi        = {pbytes[77], pbytes[76]};
    end

endmodule

[hw/rtl/ubx_nav_pvt_frame_parser.sv]
// byte-serial navigation frame parser: one rx byte per cycle, one result per good frame
// throughput: one byte accepted every cycle; input stalls only on a checksum B byte
//   while the previous result is still held by a stalled output
// result: registered, valid in the cycle after the accepted checksum B byte
// reset: parser back to sync hunt, checksums, counters and stored payload bytes cleared,
//   message id back to 0x07 and length limit back to 120
`include "ubx_nav_pvt_frame_parser_assert.svh"

module ubx_nav_pvt_frame_parser (
    input  logic               clk,
    input  logic               rst_n,
    // configuration write port
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [7:0]         cfg_data,
    // byte input
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         rx_byte,
    // result output
    output logic               out_valid,
    input  logic               out_stall,
    output logic [19:0]        time_of_day_s,
    output logic [7:0]         fix_type,
    output logic [7:0]         sat_count,
    output logic signed [31:0] longitude_e7,
    output logic signed [31:0] latitude_e7,
    output logic signed [31:0] height_msl_mm,
    output logic signed [31:0] vel_north_mm_s,
    output logic signed [31:0] vel_east_mm_s,
    output logic signed [31:0] vel_down_mm_s,
    output logic [31:0]        ground_speed_mm_s,
    output logic [31:0]        heading_e5,
    output logic [15:0]        hdop_centi
);
    import ubxpvt_pkg::*;

    typedef enum logic [3:0] {
        PH_SYNC1   = 4'd0,
        PH_SYNC2   = 4'd1,
        PH_CLASS   = 4'd2,
        PH_ID      = 4'd3,
        PH_LEN_LO  = 4'd4,
        PH_LEN_HI  = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_CK_A    = 4'd7,
        PH_CK_B    = 4'd8
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  sum_a_reg, sum_a_next;
    logic [7:0]  sum_b_reg, sum_b_next;
    logic [7:0]  frame_len_reg, frame_len_next;
    logic [6:0]  byte_count_reg, byte_count_next;
    logic [7:0]  message_id_reg;
    logic [6:0]  max_len_reg;
    logic [7:0]  pbyte_reg [FIELD_BYTES];
    logic        out_valid_reg, out_valid_next;
    nav_result_t result_reg;
    nav_result_t decoded;

    logic        in_acc;
    logic        store_en;
    logic        emit;
    logic [7:0]  add_a;
    logic [7:0]  add_b;
    logic [7:0]  count_inc;
    logic        out_blocked;
    logic        ckb_phase;
    logic        count_ok;

    // only a checksum B byte can produce a result, so only that byte waits
    assign out_blocked = out_valid_reg && out_stall;
    assign ckb_phase   = (phase_reg == PH_CK_B);
    assign in_stall    = out_blocked && ckb_phase;
    assign in_acc      = in_valid && !in_stall;

    // running fletcher sums with this byte added
    assign add_a     = sum_a_reg + rx_byte;
    assign add_b     = sum_b_reg + add_a;
    assign count_inc = {1'b0, byte_count_reg} + 8'd1;

    // parser next state
    always_comb
    begin
        phase_next      = phase_reg;
        sum_a_next      = sum_a_reg;
        sum_b_next      = sum_b_reg;
        frame_len_next  = frame_len_reg;
        byte_count_next = byte_count_reg;
        store_en        = 1'b0;
        emit            = 1'b0;
        if (in_acc)
        begin
            unique case (phase_reg)
                PH_SYNC2:
                begin
                    phase_next = (rx_byte == SYNC_SECOND) ? PH_CLASS : PH_SYNC1;
                end
                PH_CLASS:
                begin
                    sum_a_next = rx_byte;
                    sum_b_next = rx_byte;
                    phase_next = PH_ID;
                end
                PH_ID:
                begin
                    sum_a_next = add_a;
                    sum_b_next = add_b;
                    phase_next = (rx_byte == message_id_reg) ? PH_LEN_LO : PH_SYNC1;
                end
                PH_LEN_LO:
                begin
                    sum_a_next     = add_a;
                    sum_b_next     = add_b;
                    frame_len_next = rx_byte;
                    phase_next     = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    sum_a_next      = add_a;
                    sum_b_next      = add_b;
                    byte_count_next = '0;
                    if (rx_byte != 8'd0 || frame_len_reg > {1'b0, max_len_reg})
                    begin
                        frame_len_next = '0;
                        phase_next     = PH_SYNC1;
                    end
                    else if (frame_len_reg == 8'd0)
                    begin
                        phase_next = PH_CK_A;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    sum_a_next      = add_a;
                    sum_b_next      = add_b;
                    store_en        = 1'b1;
                    byte_count_next = count_inc[6:0];
                    if (count_inc == frame_len_reg)
                    begin
                        phase_next = PH_CK_A;
                    end
                end
                PH_CK_A:
                begin
                    phase_next = (sum_a_reg == rx_byte) ? PH_CK_B : PH_SYNC1;
                end
                PH_CK_B:
                begin
                    phase_next = PH_SYNC1;
                    emit       = (sum_b_reg == rx_byte);
                end
                default:
                begin
                    // hunting, also for any stray phase code
                    phase_next = (rx_byte == SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
                end
            endcase
        end
    end

    // output register handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // parser state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SYNC1;
            sum_a_reg      <= '0;
            sum_b_reg      <= '0;
            frame_len_reg  <= '0;
            byte_count_reg <= '0;
            message_id_reg <= MESSAGE_ID_RESET;
            max_len_reg    <= MAX_LEN_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            sum_a_reg      <= sum_a_next;
            sum_b_reg      <= sum_b_next;
            frame_len_reg  <= frame_len_next;
            byte_count_reg <= byte_count_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MESSAGE_ID: message_id_reg <= cfg_data;
                    CFG_MAX_LEN:    max_len_reg    <= cfg_data[6:0];
                    default:        message_id_reg <= message_id_reg;
                endcase
            end
        end
    end

    // stored payload bytes that feed result fields; later bytes only enter the checksum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FIELD_BYTES; i++)
            begin
                pbyte_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < FIELD_BYTES; i++)
            begin
                if (store_en && byte_count_reg == 7'(i))
                begin
                    pbyte_reg[i] <= rx_byte;
                end
            end
        end
    end

    // field decode from the stored bytes
    ubxpvt_decode u_decode (
        .pbytes (pbyte_reg),
        .result (decoded)
    );

    // result register, loaded when a frame checks out
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            result_reg <= decoded;
        end
    end

    assign out_valid         = out_valid_reg;
    assign time_of_day_s     = result_reg.time_of_day_s;
    assign fix_type          = result_reg.fix_type;
    assign sat_count         = result_reg.sat_count;
    assign longitude_e7      = result_reg.longitude_e7;
    assign latitude_e7       = result_reg.latitude_e7;
    assign height_msl_mm     = result_reg.height_msl_mm;
    assign vel_north_mm_s    = result_reg.vel_north_mm_s;
    assign vel_east_mm_s     = result_reg.vel_east_mm_s;
    assign vel_down_mm_s     = result_reg.vel_down_mm_s;
    assign ground_speed_mm_s = result_reg.ground_speed_mm_s;
    assign heading_e5        = result_reg.heading_e5;
    assign hdop_centi        = result_reg.hdop_centi;

    // payload counter stays below the frame length
    assign count_ok = (frame_len_reg != 8'd0) && ({1'b0, byte_count_reg} < frame_len_reg);

    // checks
    `UBX_ASSERT_IMPLY(a_hold_on_pending, out_blocked && ckb_phase, in_stall, "result pending")
    `UBX_ASSERT_NEXT(a_good_frame_emits, emit, out_valid_reg, "good frame gave no result")
    `UBX_ASSERT_IMPLY(a_payload_count, phase_reg == PH_PAYLOAD, count_ok, "count past length")

endmodule

[tb/ubx_nav_pvt_frame_parser_checker.sv]
// scoreboard for the navigation frame parser: mirrors the parser and checks every result
`timescale 1ns / 100ps

module ubx_nav_pvt_frame_parser_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [7:0]         cfg_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [7:0]         rx_byte,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [19:0]        time_of_day_s,
    input  logic [7:0]         fix_type,
    input  logic [7:0]         sat_count,
    input  logic signed [31:0] longitude_e7,
    input  logic signed [31:0] latitude_e7,
    input  logic signed [31:0] height_msl_mm,
    input  logic signed [31:0] vel_north_mm_s,
    input  logic signed [31:0] vel_east_mm_s,
    input  logic signed [31:0] vel_down_mm_s,
    input  logic [31:0]        ground_speed_mm_s,
    input  logic [31:0]        heading_e5,
    input  logic [15:0]        hdop_centi,
    output int                 fail_count,
    output int                 pending,
    output int                 results_checked
);
    import ubxpvt_pkg::*;

    localparam int STORE_DEPTH = 128;
    localparam int SHOW_LIMIT  = 10;

    typedef enum logic [3:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_CLASS,
        PH_ID,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_PAYLOAD,
        PH_CK_A,
        PH_CK_B
    } parse_phase_t;

    // mirrored parser state and register copies
    parse_phase_t phase;
    logic [7:0]   run_a;
    logic [7:0]   run_b;
    logic [7:0]   frame_len;
    logic [7:0]   byte_idx;
    logic [7:0]   store [STORE_DEPTH];
    logic [7:0]   want_id;
    logic [6:0]   len_limit;

    nav_result_t  nav_expected_q[$];
    nav_result_t  oldest;
    int           shown;

    function automatic logic [31:0] word_at(input int idx);
        return {store[idx + 3], store[idx + 2], store[idx + 1], store[idx]};
    endfunction

    // decode the stored payload into the fields of one result
    function automatic nav_result_t decode_fields();
        nav_result_t r;
        logic [7:0]  fix;
        fix = (store[20] == 8'h00) ? FIX_NONE_MAPPED : store[20];
        if (store[21] == FLAG_FIXED)
            fix = FIX_RTK_FIXED;
        if (store[21] == FLAG_FLOAT)
            fix = FIX_RTK_FLOAT;
        r.time_of_day_s     = {12'd0, store[8]} * SEC_PER_HOUR + {12'd0, store[9]} * SEC_PER_MIN
                              + {12'd0, store[10]};
        r.fix_type          = fix;
        r.sat_count         = store[23];
        r.longitude_e7      = word_at(24);
        r.latitude_e7       = word_at(28);
        r.height_msl_mm     = word_at(36);
        r.vel_north_mm_s    = word_at(48);
        r.vel_east_mm_s     = word_at(52);
        r.vel_down_mm_s     = word_at(56);
        r.ground_speed_mm_s = word_at(60);
        r.heading_e5        = word_at(64);
        r.hdop_centi        = {store[77], store[76]};
        return r;
    endfunction

    function automatic void add_to_sums(input logic [7:0] d);
        run_a = run_a + d;
        run_b = run_b + run_a;
    endfunction

    // one accepted byte through the frame state machine
    function automatic void advance_parser(input logic [7:0] d);
        case (phase)
            PH_SYNC2:
            begin
                phase = (d == SYNC_SECOND) ? PH_CLASS : PH_SYNC1;
            end
            PH_CLASS:
            begin
                run_a = d;
                run_b = d;
                phase = PH_ID;
            end
            PH_ID:
            begin
                add_to_sums(d);
                phase = (d == want_id) ? PH_LEN_LO : PH_SYNC1;
            end
            PH_LEN_LO:
            begin
                add_to_sums(d);
                frame_len = d;
                phase = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                add_to_sums(d);
                byte_idx = 8'd0;
                if (d != 8'd0 || frame_len > {1'b0, len_limit})
                begin
                    frame_len = 8'd0;
                    phase = PH_SYNC1;
                end
                else if (frame_len == 8'd0)
                    phase = PH_CK_A;
                else
                    phase = PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                add_to_sums(d);
                if (byte_idx < STORE_DEPTH)
                    store[byte_idx] = d;
                byte_idx = byte_idx + 8'd1;
                if (byte_idx == frame_len)
                    phase = PH_CK_A;
            end
            PH_CK_A:
            begin
                phase = (d == run_a) ? PH_CK_B : PH_SYNC1;
            end
            PH_CK_B:
            begin
                phase = PH_SYNC1;
                if (d == run_b)
                    nav_expected_q.push_back(decode_fields());
            end
            default:
            begin
                phase = (d == SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
            end
        endcase
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (shown < SHOW_LIMIT)
        begin
            shown++;
            $display("%0t mismatch: %s", $realtime, msg);
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] got,
                                        input logic [31:0] want);
        if (got !== want)
            note_failure($sformatf("%s expected %0h got %0h", name, want, got));
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase = PH_SYNC1;
            run_a = 8'd0;
            run_b = 8'd0;
            frame_len = 8'd0;
            byte_idx = 8'd0;
            for (int i = 0; i < STORE_DEPTH; i++)
                store[i] = 8'd0;
            want_id = MESSAGE_ID_RESET;
            len_limit = MAX_LEN_RESET;
            nav_expected_q.delete();
            fail_count = 0;
            results_checked = 0;
            shown = 0;
        end
        else
        begin
            // compare a delivered result with the oldest expectation
            if (out_valid && !out_stall)
            begin
                if (nav_expected_q.size() == 0)
                    note_failure("result delivered with nothing expected");
                else
                begin
                    oldest = nav_expected_q.pop_front();
                    results_checked++;
                    check_field("time_of_day_s", time_of_day_s, oldest.time_of_day_s);
                    check_field("fix_type", fix_type, oldest.fix_type);
                    check_field("sat_count", sat_count, oldest.sat_count);
                    check_field("longitude_e7", longitude_e7, oldest.longitude_e7);
                    check_field("latitude_e7", latitude_e7, oldest.latitude_e7);
                    check_field("height_msl_mm", height_msl_mm, oldest.height_msl_mm);
                    check_field("vel_north_mm_s", vel_north_mm_s, oldest.vel_north_mm_s);
                    check_field("vel_east_mm_s", vel_east_mm_s, oldest.vel_east_mm_s);
                    check_field("vel_down_mm_s", vel_down_mm_s, oldest.vel_down_mm_s);
                    check_field("ground_speed_mm_s", ground_speed_mm_s,
                                oldest.ground_speed_mm_s);
                    check_field("heading_e5", heading_e5, oldest.heading_e5);
                    check_field("hdop_centi", hdop_centi, oldest.hdop_centi);
                end
            end

            // accepted input byte, seen with the registers as they were before this edge
            if (in_valid && !in_stall)
                advance_parser(rx_byte);

            // register writes take effect for the following bytes
            if (cfg_we)
            begin
                if (cfg_index == CFG_MESSAGE_ID)
                    want_id = cfg_data;
                else
                    len_limit = cfg_data[6:0];
            end
        end
        pending = nav_expected_q.size();
    end

endmodule

[tb/tb_top.sv]
// top of the frame parser testbench: clock, reset, byte stimulus, receiver stalls and verdict
`timescale 1ns / 100ps

module tb_top;
    import ubxpvt_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int BYTE_TARGET = 1350;
    localparam int GOOD_TARGET = 48;

    typedef enum logic [1:0] {CK_GOOD, CK_BAD_A, CK_BAD_B} ck_mode_t;
    typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_PATTERN, RX_HEAVY} rx_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = CFG_MESSAGE_ID;
    logic [7:0]  cfg_data = 8'd0;
    logic        in_valid = 1'b0;
    logic [7:0]  rx_byte = 8'd0;
    logic        out_stall = 1'b0;
    wire         in_stall;
    wire         out_valid;

    wire [19:0]        time_of_day_s;
    wire [7:0]         fix_type;
    wire [7:0]         sat_count;
    wire signed [31:0] longitude_e7;
    wire signed [31:0] latitude_e7;
    wire signed [31:0] height_msl_mm;
    wire signed [31:0] vel_north_mm_s;
    wire signed [31:0] vel_east_mm_s;
    wire signed [31:0] vel_down_mm_s;
    wire [31:0]        ground_speed_mm_s;
    wire [31:0]        heading_e5;
    wire [15:0]        hdop_centi;

    int fail_count;
    int pending;
    int results_checked;

    // receiver control
    rx_mode_t stall_mode = RX_FREE;
    logic     hold_req = 1'b0;
    logic     hold_taken = 1'b0;
    int       hold_left = 0;
    int       stall_tick = 0;
    int       quiet_cycles = 0;

    // sender bookkeeping
    logic [7:0] body[$];
    logic [7:0] cur_id = MESSAGE_ID_RESET;
    int         cur_max = MAX_LEN_RESET;
    bit         gaps_on = 1'b0;
    int         burst_left = 0;
    int         bytes_sent = 0;
    int         frames_sent = 0;
    int         good_sent = 0;

    always #5 clk = ~clk;

    ubx_nav_pvt_frame_parser uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .rx_byte           (rx_byte),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .time_of_day_s     (time_of_day_s),
        .fix_type          (fix_type),
        .sat_count         (sat_count),
        .longitude_e7      (longitude_e7),
        .latitude_e7       (latitude_e7),
        .height_msl_mm     (height_msl_mm),
        .vel_north_mm_s    (vel_north_mm_s),
        .vel_east_mm_s     (vel_east_mm_s),
        .vel_down_mm_s     (vel_down_mm_s),
        .ground_speed_mm_s (ground_speed_mm_s),
        .heading_e5        (heading_e5),
        .hdop_centi        (hdop_centi)
    );

    ubx_nav_pvt_frame_parser_checker nav_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .rx_byte           (rx_byte),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .time_of_day_s     (time_of_day_s),
        .fix_type          (fix_type),
        .sat_count         (sat_count),
        .longitude_e7      (longitude_e7),
        .latitude_e7       (latitude_e7),
        .height_msl_mm     (height_msl_mm),
        .vel_north_mm_s    (vel_north_mm_s),
        .vel_east_mm_s     (vel_east_mm_s),
        .vel_down_mm_s     (vel_down_mm_s),
        .ground_speed_mm_s (ground_speed_mm_s),
        .heading_e5        (heading_e5),
        .hdop_centi        (hdop_centi),
        .fail_count        (fail_count),
        .pending           (pending),
        .results_checked   (results_checked)
    );

    // receiver stalls: one long hold on request, otherwise the current pattern
    always @(posedge clk)
    begin
        stall_tick <= stall_tick + 1;
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_req && !hold_taken)
        begin
            hold_taken <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            case (stall_mode)
                RX_LIGHT:   out_stall <= ($urandom_range(0, 3) == 0);
                RX_PATTERN: out_stall <= ((stall_tick % 7) < 3);
                RX_HEAVY:   out_stall <= ($urandom_range(0, 1) == 1);
                default:    out_stall <= 1'b0;
            endcase
        end
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: %0d cycles without a transfer, %0d results outstanding",
                         quiet_cycles, pending);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // offer one byte and wait until it is taken, with bursts and gaps when enabled
    task automatic send_byte(input logic [7:0] b);
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            burst_left--;
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    // sync pair, header, payload from body and the two checksum bytes
    task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                              input logic [7:0] len_lo, input logic [7:0] len_hi,
                              input ck_mode_t mode);
        logic [7:0] frame[$];
        logic [7:0] sa;
        logic [7:0] sb;
        frame = '{cls, id, len_lo, len_hi};
        foreach (body[i])
            frame.push_back(body[i]);
        sa = 8'd0;
        sb = 8'd0;
        foreach (frame[i])
        begin
            sa = sa + frame[i];
            sb = sb + sa;
        end
        if (mode == CK_BAD_A)
            sa = sa ^ 8'($urandom_range(1, 255));
        if (mode == CK_BAD_B)
            sb = sb ^ 8'($urandom_range(1, 255));
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        foreach (frame[i])
            send_byte(frame[i]);
        send_byte(sa);
        send_byte(sb);
        frames_sent++;
    endtask

    function automatic void fill_const(input int n, input logic [7:0] v);
        body.delete();
        for (int i = 0; i < n; i++)
            body.push_back(v);
    endfunction

    // random payload, often steering the fix and carrier flag bytes
    function automatic void fill_random(input int n);
        body.delete();
        for (int i = 0; i < n; i++)
            body.push_back(8'($urandom));
        if (n > 21)
        begin
            case ($urandom_range(0, 5))
                0: body[20] = 8'd0;
                1: body[21] = FLAG_FIXED;
                2: body[21] = FLAG_FLOAT;
                3:
                begin
                    body[20] = 8'd0;
                    body[21] = FLAG_FLOAT;
                end
                default: ;
            endcase
        end
    endfunction

    // mostly short payloads, some covering every field where the limit allows, some at the limit
    function automatic int pick_len(input int limit);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0 || limit == 0)
            return 0;
        if (r <= 5)
            return $urandom_range(1, (limit < 24) ? limit : 24);
        if (r <= 8)
            return $urandom_range((limit < 78) ? 1 : 78, limit);
        return limit;
    endfunction

    // stop offering and wait until every expected result has come out
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(input logic [7:0] id, input logic [6:0] max_len);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= CFG_MESSAGE_ID;
        cfg_data <= id;
        @(posedge clk);
        cfg_index <= CFG_MAX_LEN;
        cfg_data <= {1'($urandom_range(0, 1)), max_len};
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_id = id;
        cur_max = max_len;
    endtask

    // mix of good frames, broken frames and line noise
    task automatic random_traffic(input int budget, input int min_good);
        int         first_byte;
        int         first_good;
        int         pick;
        int         n;
        logic [7:0] cls;
        first_byte = bytes_sent;
        first_good = good_sent;
        while (bytes_sent - first_byte < budget || good_sent - first_good < min_good)
        begin
            pick = $urandom_range(0, 99);
            cls = 8'($urandom);
            n = pick_len(cur_max);
            if (pick < 70)
            begin
                fill_random(n);
                send_frame(cls, cur_id, 8'(n), 8'd0, CK_GOOD);
                good_sent++;
            end
            else if (pick < 78)
            begin
                fill_random(n);
                send_frame(cls, cur_id, 8'(n), 8'd0, (pick < 74) ? CK_BAD_A : CK_BAD_B);
            end
            else if (pick < 82)
            begin
                fill_random(n);
                send_frame(cls, cur_id ^ 8'($urandom_range(1, 255)), 8'(n), 8'd0, CK_GOOD);
            end
            else if (pick < 86)
            begin
                // oversize length, by the low byte or by a nonzero high byte
                fill_random($urandom_range(0, 6));
                if (cur_max < 127 && $urandom_range(0, 1) == 1)
                    send_frame(cls, cur_id, 8'($urandom_range(cur_max + 1, 255)), 8'd0, CK_GOOD);
                else
                    send_frame(cls, cur_id, 8'($urandom), 8'($urandom_range(1, 255)), CK_GOOD);
            end
            else if (pick < 90)
            begin
                // truncated payload: what follows is swallowed as payload
                fill_random(n / 2);
                send_frame(cls, cur_id, 8'(n), 8'd0, CK_GOOD);
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                begin
                    case ($urandom_range(0, 2))
                        0:       send_byte(SYNC_FIRST);
                        1:       send_byte(SYNC_SECOND);
                        default: send_byte(8'($urandom));
                    endcase
                end
            end
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: noise extremes, sync hunting, header rejects, field extremes
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        fill_const(0, 8'h00);
        send_frame(8'h01, cur_id, 8'd0, 8'd0, CK_GOOD);
        send_byte(SYNC_FIRST);
        send_byte(8'h00);
        send_frame(8'h01, cur_id + 8'd1, 8'd0, 8'd0, CK_GOOD);
        send_frame(8'h01, cur_id, 8'd0, 8'd1, CK_GOOD);
        fill_const(4, 8'h5A);
        send_frame(8'h01, cur_id, 8'd121, 8'd0, CK_GOOD);
        fill_const(120, 8'hFF);
        send_frame(8'hFF, cur_id, 8'd120, 8'd0, CK_GOOD);
        fill_const(92, 8'h00);
        body[21] = FLAG_FIXED;
        send_frame(8'h00, cur_id, 8'd92, 8'd0, CK_GOOD);
        fill_const(80, 8'h00);
        body[20] = 8'd3;
        body[21] = FLAG_FLOAT;
        foreach (body[i])
            if (i % 4 == 3)
                body[i] = 8'h80;
        send_frame(8'h01, cur_id, 8'd80, 8'd0, CK_GOOD);
        fill_random(10);
        send_frame(8'h01, cur_id, 8'd10, 8'd0, CK_GOOD);
        fill_random(5);
        send_frame(8'h01, cur_id, 8'd5, 8'd0, CK_BAD_A);
        send_frame(8'h01, cur_id, 8'd5, 8'd0, CK_BAD_B);
        fill_random(78);
        send_frame(8'h01, cur_id, 8'd78, 8'd0, CK_GOOD);

        // random phases under several register settings
        gaps_on = 1'b1;
        stall_mode <= RX_LIGHT;
        random_traffic(200, 0);

        set_config(8'h00, 7'd127);
        gaps_on = 1'b0;
        stall_mode <= RX_FREE;
        random_traffic(250, 0);

        set_config(8'hFF, 7'd0);
        gaps_on = 1'b1;
        stall_mode <= RX_PATTERN;
        random_traffic(120, 0);

        set_config(SYNC_FIRST, 7'($urandom_range(78, 126)));
        stall_mode <= RX_HEAVY;
        random_traffic(220, 0);

        set_config(8'($urandom), 7'($urandom_range(1, 30)));
        stall_mode <= RX_LIGHT;
        random_traffic(100, 0);

        // long receiver hold while zero-length frames keep coming
        gaps_on = 1'b0;
        hold_req <= 1'b1;
        fill_const(0, 8'h00);
        repeat (6)
        begin
            send_frame(8'($urandom), cur_id, 8'd0, 8'd0, CK_GOOD);
            good_sent++;
        end

        set_config(MESSAGE_ID_RESET, MAX_LEN_RESET);
        gaps_on = 1'b1;
        random_traffic((bytes_sent < BYTE_TARGET) ? BYTE_TARGET - bytes_sent : 0,
                       (good_sent < GOOD_TARGET) ? GOOD_TARGET - good_sent : 0);

        drain();
        repeat (20) @(posedge clk);

        $display("run covered %0d bytes in %0d frames over six register settings",
                 bytes_sent, frames_sent);
        $display("%0d results compared, one receiver hold of %0d cycles with input backed up",
                 results_checked, HOLD_CYCLES);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/ubxpvt_pkg.sv
hw/rtl/ubxpvt_decode.sv
hw/rtl/ubx_nav_pvt_frame_parser.sv
tb/ubx_nav_pvt_frame_parser_checker.sv
tb/tb_top.sv
